// ----- hw/rtl/lrkzg_pkg.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// lrkzg_pkg
// Shared constants and types for the longest-run-with-gaps block.
// ----------------------------------------------------------------------------
package lrkzg_pkg;

	// field widths
	localparam int unsigned LEN_W = 21;
	localparam int unsigned CFG_W = 5;

	// stream length at which the position counter saturates
	localparam int unsigned MAX_LEN = 1048576;
	localparam logic [LEN_W-1:0] LEN_SAT = LEN_W'(MAX_LEN);

	// default number of gap cells beyond the first
	localparam int unsigned DEF_MAX_GAPS = 16;

	// gap limit after reset
	localparam logic [CFG_W-1:0] GAP_LIMIT_RST = CFG_W'(1);

	// per-bit control broadcast to every gap cell
	typedef struct packed {
		logic step;   // a request is taken this cycle
		logic shift;  // a new zero run begins: move every entry one cell down
		logic load;   // bit is zero: first cell picks up the current position
		logic clear;  // final bit: drop all zero runs
	} cell_ctrl_t;

endpackage : lrkzg_pkg
`default_nettype wire

// ----- hw/rtl/lrkzg_if.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// lrkzg_if
// Valid/ready channels for the bit stream and for the result.
// ----------------------------------------------------------------------------

// bit stream channel
interface lrkzg_in_if;
	logic valid;
	logic ready;
	logic bit_value;
	logic last_bit;

	modport source (output valid, output bit_value, output last_bit, input ready);
	modport sink   (input valid, input bit_value, input last_bit, output ready);
endinterface : lrkzg_in_if

// result channel
interface lrkzg_out_if;
	logic                        valid;
	logic                        ready;
	logic [lrkzg_pkg::LEN_W-1:0] best_length;
	logic                        overflow;

	modport source (output valid, output best_length, output overflow, input ready);
	modport sink   (input valid, input best_length, input overflow, output ready);
endinterface : lrkzg_out_if
`default_nettype wire

// ----- hw/rtl/lrkzg_cell.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// lrkzg_cell
// One entry of the zero-run end chain: holds the end position of one recent
// zero run and a flag that the entry is occupied, and offers its next value
// as the window start when the gap limit selects it.
// ----------------------------------------------------------------------------
module lrkzg_cell #(
	parameter int unsigned IDX_W = 5,
	parameter int unsigned INDEX = 0
) (
	input  wire                               clk,
	input  wire                               arst_n,
	input  wire lrkzg_pkg::cell_ctrl_t        ctrl,
	input  wire  [IDX_W-1:0]                  tap_sel,
	input  wire  [lrkzg_pkg::LEN_W-1:0]       prev_run_end,
	input  wire                               prev_valid,
	output logic [lrkzg_pkg::LEN_W-1:0]       run_end,
	output logic                              run_valid,
	output logic [lrkzg_pkg::LEN_W-1:0]       tap_end,
	output logic                              tap_hit
);
	import lrkzg_pkg::*;

	localparam bit FIRST = (INDEX == 0);

	logic [LEN_W-1:0] run_end_q;
	logic             run_valid_q;
	logic [LEN_W-1:0] run_end_d;
	logic             run_valid_d;
	logic             picked;

	// next entry: take the neighbour's on a new run, the first cell also
	// follows the position through a run of zeros
	always_comb begin
		run_end_d   = (ctrl.shift || (ctrl.load && FIRST)) ? prev_run_end : run_end_q;
		run_valid_d = ctrl.shift ? prev_valid : run_valid_q;
		picked      = (tap_sel == IDX_W'(INDEX));
		tap_end     = picked ? run_end_d : '0;
		tap_hit     = picked && run_valid_d;
	end

	// occupancy flag
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			run_valid_q <= 1'b0;
		end else if (ctrl.step) begin
			run_valid_q <= ctrl.clear ? 1'b0 : run_valid_d;
		end
	end

	// end position, only read while occupied
	always_ff @(posedge clk) begin
		if (ctrl.step) begin
			run_end_q <= run_end_d;
		end
	end

	assign run_end   = run_end_q;
	assign run_valid = run_valid_q;

endmodule : lrkzg_cell
`default_nettype wire

// ----- hw/rtl/longest_run_with_k_zero_gaps_core.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// longest_run_with_k_zero_gaps_core
// Longest stretch of a bit stream holding at most gap_limit zero runs.
// ----------------------------------------------------------------------------
// Usage:
//   stream carries one bit per request (bit_value, last_bit). On the request
//   with last_bit set, one result request follows on result: best_length is
//   the longest stretch with at most gap_limit zero runs, saturated at
//   MAX_LEN, and overflow flags a stream longer than MAX_LEN bits.
//   Throughput is one bit per cycle while stream.ready is high: each bit passes
//   once through the chain of MAX_GAPS+1 gap cells, one subtract and one compare.
//   The final bit's result is registered in the output register or the skid.
//   gap_limit is written through cfg_we/cfg_wdata while the block is idle;
//   values above MAX_GAPS act as MAX_GAPS.
//   Reset clears the stream state and sets gap_limit to 1; no clearing pass
//   is needed, the block takes requests as soon as reset is released.
//   The result sits in an output register backed by a skid register, so
//   the stream keeps flowing while a result waits; stream.ready drops only
//   when both hold a result the receiver has not taken.
//   After each final bit the stream state returns to its reset value.
// ----------------------------------------------------------------------------
module longest_run_with_k_zero_gaps_core #(
	parameter int unsigned MAX_GAPS = lrkzg_pkg::DEF_MAX_GAPS
) (
	input  wire                         clk,
	input  wire                         arst_n,
	input  wire                         cfg_we,
	input  wire  [lrkzg_pkg::CFG_W-1:0] cfg_wdata,
	lrkzg_in_if.sink                    stream,
	lrkzg_out_if.source                 result
);
	import lrkzg_pkg::*;

	localparam int unsigned DEPTH = MAX_GAPS + 1;
	localparam int unsigned IDX_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;

	// configuration
	logic [CFG_W-1:0] gap_limit_q;

	// stream state
	logic [LEN_W-1:0] pos_q;
	logic             inside_q;
	logic [LEN_W-1:0] best_q;
	logic             ovf_q;

	// output register and skid
	logic             out_v_q;
	logic [LEN_W-1:0] out_len_q;
	logic             out_ovf_q;
	logic             skid_v_q;
	logic [LEN_W-1:0] skid_len_q;
	logic             skid_ovf_q;

	logic             take;
	logic             push;
	logic             pop;
	logic [IDX_W-1:0] k_sel;
	logic [LEN_W-1:0] pos_new;
	logic             ovf_new;
	logic [LEN_W-1:0] cand;
	logic [LEN_W-1:0] best_new;
	logic [LEN_W-1:0] sel_end;
	logic             sel_hit;
	cell_ctrl_t       ctrl;

	logic [LEN_W-1:0] chain_end   [DEPTH+1];
	logic             chain_valid [DEPTH+1];
	logic [LEN_W-1:0] tap_end     [DEPTH];
	logic             tap_hit     [DEPTH];

	// handshake
	assign stream.ready = !skid_v_q;
	assign take         = stream.valid && stream.ready;
	assign push         = take && stream.last_bit;
	assign pop          = out_v_q && result.ready;

	// gap limit register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			gap_limit_q <= GAP_LIMIT_RST;
		end else if (cfg_we) begin
			gap_limit_q <= cfg_wdata;
		end
	end

	// effective gap limit, capped at MAX_GAPS, the index of the last gap cell
	assign k_sel = (32'(gap_limit_q) > MAX_GAPS) ? IDX_W'(MAX_GAPS) : IDX_W'(gap_limit_q);

	// saturating position
	always_comb begin
		ovf_new = ovf_q || (pos_q >= LEN_SAT);
		pos_new = (pos_q >= LEN_SAT) ? pos_q : pos_q + LEN_W'(1);
	end

	// cell control
	always_comb begin
		ctrl.step  = take;
		ctrl.load  = !stream.bit_value;
		ctrl.shift = !stream.bit_value && !inside_q;
		ctrl.clear = stream.last_bit;
	end

	// chain of gap cells, entry 0 holds the most recent zero run
	assign chain_end[0]   = pos_new;
	assign chain_valid[0] = 1'b1;

	for (genvar i = 0; i < DEPTH; i++) begin : g_cell
		lrkzg_cell #(
			.IDX_W (IDX_W),
			.INDEX (i)
		) u_cell (
			.clk          (clk),
			.arst_n       (arst_n),
			.ctrl         (ctrl),
			.tap_sel      (k_sel),
			.prev_run_end (chain_end[i]),
			.prev_valid   (chain_valid[i]),
			.run_end      (chain_end[i+1]),
			.run_valid    (chain_valid[i+1]),
			.tap_end      (tap_end[i]),
			.tap_hit      (tap_hit[i])
		);
	end

	// gather the selected cell's window start
	always_comb begin
		sel_end = '0;
		sel_hit = 1'b0;
		for (int i = 0; i < DEPTH; i++) begin
			sel_end = sel_end | tap_end[i];
			sel_hit = sel_hit | tap_hit[i];
		end
	end

	// candidate window and running maximum
	always_comb begin
		cand     = sel_hit ? pos_new - sel_end : pos_new;
		best_new = (cand > best_q) ? cand : best_q;
	end

	// stream state, cleared after the final bit
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_q    <= '0;
			inside_q <= 1'b0;
			best_q   <= '0;
			ovf_q    <= 1'b0;
		end else if (take) begin
			if (stream.last_bit) begin
				pos_q    <= '0;
				inside_q <= 1'b0;
				best_q   <= '0;
				ovf_q    <= 1'b0;
			end else begin
				pos_q    <= pos_new;
				inside_q <= !stream.bit_value;
				best_q   <= best_new;
				ovf_q    <= ovf_new;
			end
		end
	end

	// output and skid occupancy
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_v_q  <= 1'b0;
			skid_v_q <= 1'b0;
		end else if (pop) begin
			if (skid_v_q) begin
				skid_v_q <= 1'b0;
			end else begin
				out_v_q <= push;
			end
		end else if (push) begin
			if (out_v_q) begin
				skid_v_q <= 1'b1;
			end else begin
				out_v_q <= 1'b1;
			end
		end
	end

	// output and skid data
	always_ff @(posedge clk) begin
		if (pop && skid_v_q) begin
			out_len_q <= skid_len_q;
			out_ovf_q <= skid_ovf_q;
		end else if (push && (!out_v_q || pop)) begin
			out_len_q <= best_new;
			out_ovf_q <= ovf_new;
		end
		if (push && out_v_q && !pop) begin
			skid_len_q <= best_new;
			skid_ovf_q <= ovf_new;
		end
	end

	assign result.valid       = out_v_q;
	assign result.best_length = out_len_q;
	assign result.overflow    = out_ovf_q;

	// skid only fills behind a waiting result
	a_skid_behind_out: assert property (@(posedge clk) disable iff (!arst_n)
		skid_v_q |-> out_v_q)
		else $error("skid holds a result while the output register is empty");

	// a final bit always leaves a result waiting
	a_final_gives_result: assert property (@(posedge clk) disable iff (!arst_n)
		push |=> out_v_q)
		else $error("final bit taken but no result pending");

	// overflow only once the position has saturated
	a_ovf_saturated: assert property (@(posedge clk) disable iff (!arst_n)
		ovf_q |-> (pos_q == LEN_SAT))
		else $error("overflow set before the position saturated");

	// the best window never exceeds the bits seen
	a_best_bounded: assert property (@(posedge clk) disable iff (!arst_n)
		best_q <= pos_q)
		else $error("best length exceeds the position");

endmodule : longest_run_with_k_zero_gaps_core
`default_nettype wire

// ----- test/testbench.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for longest_run_with_k_zero_gaps_core.
// Bits are queued by one process, driven by a clocked driver and scored
// against a software tracker of the zero runs, per field, on every result.
// The run walks through several gap limits (0, 31 and the boundary values)
// and phases of sender idling and receiver stalls.
// ----------------------------------------------------------------------------
module testbench;
	import lrkzg_pkg::*;

	localparam int unsigned CYCLE_LIMIT = 3000000;
	localparam int unsigned SETTLE_CYCLES = 4;

	typedef struct {
		logic value;
		logic last;
	} stream_bit_t;

	typedef struct {
		logic [LEN_W-1:0] best_length;
		logic             overflow;
	} length_result_t;

	logic             clk = 1'b0;
	logic             arst_n;
	logic             cfg_we;
	logic [CFG_W-1:0] cfg_wdata;

	lrkzg_in_if  stream_if ();
	lrkzg_out_if result_if ();

	longest_run_with_k_zero_gaps_core uut (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_wdata (cfg_wdata),
		.stream    (stream_if),
		.result    (result_if)
	);

	// bits waiting to go out, and lengths the block owes us
	stream_bit_t    bits_to_send [$];
	length_result_t awaited_lengths [$];
	stream_bit_t    next_bit;

	// tracker state, mirrors the block
	logic [CFG_W-1:0] gap_cfg;
	logic [LEN_W-1:0] run_pos;
	logic             prev_zero;
	logic [LEN_W-1:0] run_ends [DEF_MAX_GAPS+1];
	logic [CFG_W-1:0] zero_runs;
	logic [LEN_W-1:0] best_run;
	logic             ovf_seen;

	int unsigned send_idle_pct = 0;
	int unsigned recv_stall_pct = 0;
	int unsigned cycles = 0;
	int unsigned bits_accepted = 0;
	int unsigned streams_queued = 0;
	int unsigned results_checked = 0;
	int unsigned mismatches = 0;

	always #10 clk = ~clk;

	task automatic report_mismatch(input string what);
		mismatches++;
		if (mismatches <= 40)
			$display("mismatch at cycle %0d: %s", cycles, what);
	endtask

	task automatic clear_tracker();
		run_pos = '0;
		prev_zero = 1'b0;
		foreach (run_ends[i])
			run_ends[i] = '0;
		zero_runs = '0;
		best_run = '0;
		ovf_seen = 1'b0;
	endtask

	// one accepted bit: update the zero-run ends and the best window
	task automatic step_gap_tracker(input logic b, input logic fin);
		int unsigned      k;
		logic [LEN_W-1:0] cand;
		k = (gap_cfg > DEF_MAX_GAPS) ? DEF_MAX_GAPS : gap_cfg;
		if (run_pos >= LEN_SAT)
			ovf_seen = 1'b1;
		else
			run_pos = run_pos + 1'b1;
		if (!b) begin
			if (!prev_zero) begin
				for (int i = DEF_MAX_GAPS; i > 0; i--)
					run_ends[i] = run_ends[i-1];
				if (zero_runs <= DEF_MAX_GAPS)
					zero_runs = zero_runs + 1'b1;
			end
			run_ends[0] = run_pos;
			prev_zero = 1'b1;
		end else begin
			prev_zero = 1'b0;
		end
		cand = (zero_runs > k) ? run_pos - run_ends[k] : run_pos;
		if (cand > best_run)
			best_run = cand;
		if (fin) begin
			awaited_lengths.push_back('{best_length: best_run, overflow: ovf_seen});
			clear_tracker();
		end
	endtask

	task automatic push_bit(input logic v, input logic fin);
		bits_to_send.push_back('{value: v, last: fin});
		if (fin)
			streams_queued++;
	endtask

	// directed stream from a string of '0' and '1', first bit leftmost
	task automatic queue_pattern(input string pat);
		for (int i = 0; i < pat.len(); i++)
			push_bit(pat[i] == "1", i == pat.len() - 1);
	endtask

	// random stream: mostly short, sometimes long, with a random zero density
	task automatic queue_random_stream(output int unsigned len);
		int unsigned zero_pct;
		len = ($urandom_range(0, 9) == 0) ? $urandom_range(17, 200) : $urandom_range(1, 16);
		case ($urandom_range(0, 3))
			0: begin
				zero_pct = 10;
			end
			1: begin
				zero_pct = 35;
			end
			2: begin
				zero_pct = 60;
			end
			default: begin
				zero_pct = 90;
			end
		endcase
		for (int unsigned i = 0; i < len; i++)
			push_bit($urandom_range(0, 99) >= zero_pct, i == len - 1);
	endtask

	// wait for every queued bit to go and every result to come back
	task automatic wait_until_drained();
		while (bits_to_send.size() != 0 || stream_if.valid || awaited_lengths.size() != 0)
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic write_gap_limit(input logic [CFG_W-1:0] v);
		wait_until_drained();
		cfg_we <= 1'b1;
		cfg_wdata <= v;
		@(posedge clk);
		cfg_we <= 1'b0;
		gap_cfg = v;
		@(posedge clk);
	endtask

	task automatic run_random_phase(input int unsigned n_bits, input int unsigned idle,
			input int unsigned stall, input logic [CFG_W-1:0] gap, input bit pause_midway);
		int unsigned sent;
		int unsigned len;
		bit          paused;
		sent = 0;
		paused = 1'b0;
		write_gap_limit(gap);
		send_idle_pct = idle;
		recv_stall_pct = stall;
		while (sent < n_bits) begin
			queue_random_stream(len);
			sent += len;
			// sender holds off until the block has answered everything
			if (pause_midway && !paused && sent >= n_bits / 2) begin
				wait_until_drained();
				paused = 1'b1;
			end
		end
	endtask

	// driver: offer the next bit, score it in the tracker once taken
	always @(posedge clk) begin
		if (!arst_n) begin
			stream_if.valid <= 1'b0;
		end else begin
			if (stream_if.valid && stream_if.ready) begin
				step_gap_tracker(stream_if.bit_value, stream_if.last_bit);
				bits_accepted++;
			end
			if (!stream_if.valid || stream_if.ready) begin
				if (bits_to_send.size() != 0 && $urandom_range(0, 99) >= send_idle_pct) begin
					next_bit = bits_to_send.pop_front();
					stream_if.valid <= 1'b1;
					stream_if.bit_value <= next_bit.value;
					stream_if.last_bit <= next_bit.last;
				end else begin
					stream_if.valid <= 1'b0;
				end
			end
		end
	end

	// monitor: compare each result request with the oldest owed length
	always @(posedge clk) begin
		if (!arst_n) begin
			result_if.ready <= 1'b0;
		end else begin
			if (result_if.valid && result_if.ready) begin
				results_checked++;
				if (awaited_lengths.size() == 0) begin
					report_mismatch($sformatf("unexpected result length %0d overflow %0b",
						result_if.best_length, result_if.overflow));
				end else begin
					if (result_if.best_length !== awaited_lengths[0].best_length)
						report_mismatch($sformatf("best_length %0d, expected %0d",
							result_if.best_length, awaited_lengths[0].best_length));
					if (result_if.overflow !== awaited_lengths[0].overflow)
						report_mismatch($sformatf("overflow %0b, expected %0b",
							result_if.overflow, awaited_lengths[0].overflow));
					void'(awaited_lengths.pop_front());
				end
			end
			result_if.ready <= ($urandom_range(0, 99) >= recv_stall_pct);
		end
	end

	// watchdog
	always @(posedge clk) begin
		cycles++;
		if (cycles == CYCLE_LIMIT) begin
			$display("timeout with %0d results outstanding", awaited_lengths.size());
			$display("CHECK FAILED");
			$finish;
		end
	end

	// stimulus
	initial begin
		stream_if.valid = 1'b0;
		stream_if.bit_value = 1'b0;
		stream_if.last_bit = 1'b0;
		result_if.ready = 1'b0;
		cfg_we = 1'b0;
		cfg_wdata = '0;
		arst_n = 1'b0;
		gap_cfg = GAP_LIMIT_RST;
		clear_tracker();
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed: reset gap limit of one, single bits, then limit 0 and an oversize limit
		queue_pattern("1");
		queue_pattern("0");
		queue_pattern("0010110");
		write_gap_limit('0);
		queue_pattern("110111");
		queue_pattern("0");
		write_gap_limit('1);
		queue_pattern("01010");

		// random phases
		run_random_phase(210, 0, 0, CFG_W'(DEF_MAX_GAPS), 1'b0);
		run_random_phase(210, 84, 0, CFG_W'(2), 1'b1);
		run_random_phase(210, 0, 84, CFG_W'($urandom_range(0, 31)), 1'b0);
		run_random_phase(210, 21, 21, CFG_W'(DEF_MAX_GAPS + 1), 1'b0);

		wait_until_drained();
		$display("sent %0d bits in %0d streams, checked %0d results, %0d mismatches",
			bits_accepted, streams_queued, results_checked, mismatches);
		$display("gap limits 0, 1, 2, 16, 17, 31 and a random one; idle, stall and drain phases");
		if (mismatches == 0)
			$display("CHECK OK");
		else
			$display("CHECK FAILED");
		$finish;
	end

endmodule : testbench
`default_nettype wire
